// File: design/blmc_pkg.sv
// Package for the box letterbox map and clip block.
// Holds widths, register indexes and the payload structs shared across the files.
package blmc_pkg;

   localparam int COORD_BITS = 12;
   localparam int IN_BITS    = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * COORD_BITS;
   localparam int NUM_BITS   = 2 * COORD_BITS + 2;
   localparam int SNUM_BITS  = NUM_BITS + 2;
   localparam int DIV_BITS   = COORD_BITS + 1;
   localparam int LANES      = 4;
   localparam int ADDR_BITS  = 5;
   localparam int DATA_BITS  = 32;
   localparam int IDX_BITS   = ADDR_BITS - 2;

   // Lane numbers inside the divider chain.
   localparam int LANE_X = 0;
   localparam int LANE_Y = 1;
   localparam int LANE_W = 2;
   localparam int LANE_H = 3;

   typedef enum logic [IDX_BITS-1:0] {
      REG_FRAME_W   = 3'd0,
      REG_FRAME_H   = 3'd1,
      REG_PREVIEW_W = 3'd2,
      REG_PREVIEW_H = 3'd3,
      REG_MODE      = 3'd4
   } reg_index_type;

   // One lane of the restoring divider: partial remainder and the
   // numerator bits still to go, with quotient bits shifted in below.
   typedef struct packed {
      logic [DIV_BITS-1:0] rem;
      logic [NUM_BITS-1:0] nq;
   } lane_type;

   typedef struct packed {
      lane_type [LANES-1:0] lane;
      logic [DIV_BITS-1:0]  divisor;
      logic                 neg_x;
      logic                 neg_y;
      logic                 zero;
   } cell_data_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] disp_x;
      logic [COORD_BITS-1:0] disp_y;
      logic [COORD_BITS-1:0] disp_w;
      logic [COORD_BITS-1:0] disp_h;
   } rsp_data_type;

endpackage

// File: design/blmc_if.sv
// Valid/ready channel interfaces for box requests and mapped results.
// Depends on blmc_pkg for the field widths.
interface blmc_req_if import blmc_pkg::*; ;
   logic                        valid;
   logic                        ready;
   logic signed [IN_BITS-1:0]   box_x;
   logic signed [IN_BITS-1:0]   box_y;
   logic [COORD_BITS-1:0]       box_w;
   logic [COORD_BITS-1:0]       box_h;

   modport source (output valid, box_x, box_y, box_w, box_h, input ready);
   modport sink (input valid, box_x, box_y, box_w, box_h, output ready);
endinterface

interface blmc_rsp_if import blmc_pkg::*; ;
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] disp_x;
   logic [COORD_BITS-1:0] disp_y;
   logic [COORD_BITS-1:0] disp_w;
   logic [COORD_BITS-1:0] disp_h;

   modport source (output valid, disp_x, disp_y, disp_w, disp_h, input ready);
   modport sink (input valid, disp_x, disp_y, disp_w, disp_h, output ready);
endinterface

// File: design/box_letterbox_map_clip.sv
// Top level: maps a box from frame to preview coordinates and clips it.
// Depends on blmc_pkg, blmc_if and blmc_cell.
//
//   channel   direction  handshake                 payload
//   req       in         valid / ready             box_x, box_y, box_w, box_h
//   rsp       out        valid / ready             disp_x, disp_y, disp_w, disp_h
//   csr       in         APB psel/penable/pready   frame and preview sizes, mode
//
// One request per cycle while the skid stage is empty; a result passes stages 1 to 3,
// the chain of one-bit divider cells, stage 5 and the output register.
// Reset clears all valid bits and the configuration registers; nothing else.
// A stalled result is held in the output register and a one-entry skid stage
// catches the next; while the skid stage is full the whole pipeline holds.
module box_letterbox_map_clip import blmc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   blmc_req_if.sink              req,
   blmc_rsp_if.source            rsp,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [ADDR_BITS-1:0]  paddr,
   input  logic [DATA_BITS-1:0]  pwdata,
   output logic [DATA_BITS-1:0]  prdata,
   output logic                  pready
);

   // Configuration registers.
   logic [COORD_BITS-1:0] frame_w_ff, frame_h_ff, prev_w_ff, prev_h_ff;
   logic                  mode_ff;
   reg_index_type         csr_idx;
   logic                  csr_wr;

   assign csr_idx = reg_index_type'(paddr[ADDR_BITS-1:2]);
   assign csr_wr  = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_w_ff <= '0;
         frame_h_ff <= '0;
         prev_w_ff  <= '0;
         prev_h_ff  <= '0;
         mode_ff    <= 1'b0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_FRAME_W:   frame_w_ff <= pwdata[COORD_BITS-1:0];
            REG_FRAME_H:   frame_h_ff <= pwdata[COORD_BITS-1:0];
            REG_PREVIEW_W: prev_w_ff  <= pwdata[COORD_BITS-1:0];
            REG_PREVIEW_H: prev_h_ff  <= pwdata[COORD_BITS-1:0];
            REG_MODE:      mode_ff    <= pwdata[0];
            default:       ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_FRAME_W:   prdata = DATA_BITS'(frame_w_ff);
         REG_FRAME_H:   prdata = DATA_BITS'(frame_h_ff);
         REG_PREVIEW_W: prdata = DATA_BITS'(prev_w_ff);
         REG_PREVIEW_H: prdata = DATA_BITS'(prev_h_ff);
         REG_MODE:      prdata = DATA_BITS'(mode_ff);
         default:       prdata = '0;
      endcase
   end

   // The pipeline advances as long as the skid stage is empty.
   logic en;
   logic skid_v_ff;
   assign en        = !skid_v_ff;
   assign req.ready = en;

   // Stage 1: ratio ordering by cross products, and the zero-size flag.
   logic [PROD_BITS-1:0] cross_w, cross_h;
   logic                 width_smaller;
   logic                 s1_v_ff, s1_sel_w_ff, s1_zero_ff;
   logic signed [IN_BITS-1:0] s1_x_ff, s1_y_ff;
   logic [COORD_BITS-1:0]     s1_w_ff, s1_h_ff;

   assign cross_w       = prev_w_ff * frame_h_ff;
   assign cross_h       = prev_h_ff * frame_w_ff;
   assign width_smaller = cross_w <= cross_h;

   always_ff @(posedge clock) begin
      if (en) begin
         s1_x_ff     <= req.box_x;
         s1_y_ff     <= req.box_y;
         s1_w_ff     <= req.box_w;
         s1_h_ff     <= req.box_h;
         s1_sel_w_ff <= mode_ff ? width_smaller : !width_smaller;
         s1_zero_ff  <= (frame_w_ff == '0) || (frame_h_ff == '0) ||
                        (prev_w_ff == '0) || (prev_h_ff == '0);
      end
   end

   // Stage 2: pick the scale P/Q and form all products with it.
   logic [COORD_BITS-1:0] p, q;
   logic                  s2_v_ff, s2_zero_ff;
   logic [COORD_BITS-1:0] s2_q_ff;
   logic [PROD_BITS-1:0]  s2_dwq_ff, s2_swp_ff, s2_dhq_ff, s2_shp_ff;
   logic [PROD_BITS-1:0]  s2_bwp_ff, s2_bhp_ff;
   logic signed [PROD_BITS+1:0] s2_bxp_ff, s2_byp_ff;

   assign p = s1_sel_w_ff ? prev_w_ff : prev_h_ff;
   assign q = s1_sel_w_ff ? frame_w_ff : frame_h_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s2_q_ff    <= q;
         s2_zero_ff <= s1_zero_ff;
         s2_dwq_ff  <= prev_w_ff * q;
         s2_swp_ff  <= frame_w_ff * p;
         s2_dhq_ff  <= prev_h_ff * q;
         s2_shp_ff  <= frame_h_ff * p;
         s2_bwp_ff  <= s1_w_ff * p;
         s2_bhp_ff  <= s1_h_ff * p;
         s2_bxp_ff  <= (PROD_BITS+2)'(s1_x_ff * $signed({1'b0, p}));
         s2_byp_ff  <= (PROD_BITS+2)'(s1_y_ff * $signed({1'b0, p}));
      end
   end

   // Stage 3: signed numerators over the common denominator 2Q.
   logic signed [SNUM_BITS-1:0] s3_n_ff [LANES];
   logic                        s3_v_ff, s3_zero_ff;
   logic [COORD_BITS-1:0]       s3_q_ff;
   logic signed [SNUM_BITS-1:0] q_s;

   assign q_s = signed'(SNUM_BITS'(s2_q_ff));

   always_ff @(posedge clock) begin
      if (en) begin
         s3_q_ff    <= s2_q_ff;
         s3_zero_ff <= s2_zero_ff;
         s3_n_ff[LANE_X] <= signed'(SNUM_BITS'(s2_dwq_ff)) - signed'(SNUM_BITS'(s2_swp_ff))
                            + (SNUM_BITS'(s2_bxp_ff) <<< 1) + q_s;
         s3_n_ff[LANE_Y] <= signed'(SNUM_BITS'(s2_dhq_ff)) - signed'(SNUM_BITS'(s2_shp_ff))
                            + (SNUM_BITS'(s2_byp_ff) <<< 1) + q_s;
         s3_n_ff[LANE_W] <= (signed'(SNUM_BITS'(s2_bwp_ff)) <<< 1) + q_s;
         s3_n_ff[LANE_H] <= (signed'(SNUM_BITS'(s2_bhp_ff)) <<< 1) + q_s;
      end
   end

   // Divider input: a negative numerator is divided as |n| + d - 1 so the
   // negated quotient is the floor.
   logic                        cell_v [NUM_BITS+1];
   cell_data_type               cell_d [NUM_BITS+1];
   logic [DIV_BITS-1:0]         div_d;
   logic signed [SNUM_BITS-1:0] mag [LANES];

   assign div_d = {s3_q_ff, 1'b0};

   always_comb begin
      cell_d[0].divisor = div_d;
      cell_d[0].zero    = s3_zero_ff;
      cell_d[0].neg_x   = s3_n_ff[LANE_X] < 0;
      cell_d[0].neg_y   = s3_n_ff[LANE_Y] < 0;
      for (int l = 0; l < LANES; l++) begin
         if (s3_n_ff[l] < 0) begin
            mag[l] = -s3_n_ff[l] + signed'(SNUM_BITS'(div_d)) - SNUM_BITS'(1);
         end else begin
            mag[l] = s3_n_ff[l];
         end
         cell_d[0].lane[l].rem = '0;
         cell_d[0].lane[l].nq  = mag[l][NUM_BITS-1:0];
      end
   end
   assign cell_v[0] = s3_v_ff;

   // Chain of divider cells, one quotient bit each.
   for (genvar k = 0; k < NUM_BITS; k++) begin : g_cell
      blmc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (cell_v[k]),
         .in_data   (cell_d[k]),
         .out_valid (cell_v[k+1]),
         .out_data  (cell_d[k+1])
      );
   end

   // Stage 5: restore the sign of the edge quotients.
   logic signed [SNUM_BITS-1:0] s5_r_ff [LANES];
   logic                        s5_v_ff, s5_zero_ff;
   logic signed [SNUM_BITS-1:0] quo [LANES];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         quo[l] = signed'(SNUM_BITS'(cell_d[NUM_BITS].lane[l].nq));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_zero_ff      <= cell_d[NUM_BITS].zero;
         s5_r_ff[LANE_X] <= cell_d[NUM_BITS].neg_x ? -quo[LANE_X] : quo[LANE_X];
         s5_r_ff[LANE_Y] <= cell_d[NUM_BITS].neg_y ? -quo[LANE_Y] : quo[LANE_Y];
         s5_r_ff[LANE_W] <= quo[LANE_W];
         s5_r_ff[LANE_H] <= quo[LANE_H];
      end
   end

   // Valid bits of the front and back stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req.valid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s5_v_ff <= cell_v[NUM_BITS];
      end
   end

   // Clip to the preview; an empty box or zero sizes give all zeros.
   logic signed [SNUM_BITS-1:0] x0, y0, x1, y1, x_end, y_end, dw_s, dh_s;
   logic                        empty;
   rsp_data_type                clip;

   assign dw_s  = signed'(SNUM_BITS'(prev_w_ff));
   assign dh_s  = signed'(SNUM_BITS'(prev_h_ff));
   assign x_end = s5_r_ff[LANE_X] + s5_r_ff[LANE_W];
   assign y_end = s5_r_ff[LANE_Y] + s5_r_ff[LANE_H];
   assign x0    = (s5_r_ff[LANE_X] > 0) ? s5_r_ff[LANE_X] : '0;
   assign y0    = (s5_r_ff[LANE_Y] > 0) ? s5_r_ff[LANE_Y] : '0;
   assign x1    = (x_end < dw_s) ? x_end : dw_s;
   assign y1    = (y_end < dh_s) ? y_end : dh_s;
   assign empty = s5_zero_ff || (x1 <= x0) || (y1 <= y0);

   always_comb begin
      if (empty) begin
         clip = '0;
      end else begin
         clip.disp_x = x0[COORD_BITS-1:0];
         clip.disp_y = y0[COORD_BITS-1:0];
         clip.disp_w = COORD_BITS'(x1 - x0);
         clip.disp_h = COORD_BITS'(y1 - y0);
      end
   end

   // Output register and skid stage.
   logic         out_v_ff;
   rsp_data_type out_ff, skid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (rsp.ready) begin
            skid_v_ff <= 1'b0;
         end
      end else if (!out_v_ff || rsp.ready) begin
         out_v_ff <= s5_v_ff;
      end else begin
         skid_v_ff <= s5_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (rsp.ready) begin
            out_ff <= skid_ff;
         end
      end else if (!out_v_ff || rsp.ready) begin
         out_ff <= clip;
      end else begin
         skid_ff <= clip;
      end
   end

   assign rsp.valid  = out_v_ff;
   assign rsp.disp_x = out_ff.disp_x;
   assign rsp.disp_y = out_ff.disp_y;
   assign rsp.disp_w = out_ff.disp_w;
   assign rsp.disp_h = out_ff.disp_h;

   // The skid stage only fills behind a held result.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid stage full while output register empty");

   // An empty result is all zeros.
   a_empty_all_zero: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && (out_ff.disp_w == '0)) |->
      ((out_ff.disp_h == '0) && (out_ff.disp_x == '0) && (out_ff.disp_y == '0)))
      else $error("empty result with nonzero fields");

   // A delivered box stays inside the preview.
   a_inside_preview: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && (out_ff.disp_w != '0)) |->
      (({1'b0, out_ff.disp_x} + {1'b0, out_ff.disp_w} <= {1'b0, prev_w_ff}) &&
       ({1'b0, out_ff.disp_y} + {1'b0, out_ff.disp_h} <= {1'b0, prev_h_ff})))
      else $error("result box extends past the preview");

endmodule

// File: design/blmc_cell.sv
// One cell of the divider chain: a restoring step on all four lanes.
// Depends on blmc_pkg.
module blmc_cell import blmc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  cell_data_type in_data,
   output logic          out_valid,
   output cell_data_type out_data
);

   logic          valid_ff;
   cell_data_type data_ff;
   cell_data_type data_in;
   logic [DIV_BITS:0] trial [LANES];

   // Shift in the next numerator bit and subtract the divisor when it fits.
   always_comb begin
      data_in = in_data;
      for (int l = 0; l < LANES; l++) begin
         trial[l] = {in_data.lane[l].rem, in_data.lane[l].nq[NUM_BITS-1]};
         if (trial[l] >= {1'b0, in_data.divisor}) begin
            data_in.lane[l].rem = DIV_BITS'(trial[l] - {1'b0, in_data.divisor});
            data_in.lane[l].nq  = {in_data.lane[l].nq[NUM_BITS-2:0], 1'b1};
         end else begin
            data_in.lane[l].rem = trial[l][DIV_BITS-1:0];
            data_in.lane[l].nq  = {in_data.lane[l].nq[NUM_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: dv/tb.sv
// Testbench for box_letterbox_map_clip: drives box requests, predicts the mapped results.
// Depends on blmc_pkg, blmc_if and the top level of the block.
`timescale 1ns / 1ps

module tb import blmc_pkg::*; ;

   typedef struct {
      logic signed [IN_BITS-1:0] x;
      logic signed [IN_BITS-1:0] y;
      logic [COORD_BITS-1:0]     w;
      logic [COORD_BITS-1:0]     h;
      bit                        has_exp;
      rsp_data_type              exp;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [ADDR_BITS-1:0] paddr = '0;
   logic [DATA_BITS-1:0] pwdata = '0;
   logic [DATA_BITS-1:0] prdata;
   logic pready;

   blmc_req_if req_if ();
   blmc_rsp_if rsp_if ();

   box_letterbox_map_clip u_dut (
      .clock(clock), .reset(reset), .req(req_if.sink), .rsp(rsp_if.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the configuration registers.
   longint frame_w, frame_h, prev_w, prev_h;
   bit     letterbox;

   rsp_data_type expected_boxes[$];
   int  errors = 0;
   int  send_idle_pct = 0, recv_idle_pct = 0;
   bit  recv_hold = 1'b0;
   int  quiet_cycles = 0;
   localparam int QUIET_LIMIT = 5000;
   localparam int LATENCY = NUM_BITS + 5;

   initial begin
      req_if.valid = 1'b0;
      req_if.box_x = '0;
      req_if.box_y = '0;
      req_if.box_w = '0;
      req_if.box_h = '0;
      rsp_if.ready = 1'b0;
   end

   function automatic longint floor_div(longint num, longint den);
      if (num >= 0) return num / den;
      return -((-num + den - 1) / den);
   endfunction

   // Maps one box into preview space and clips it.
   function automatic rsp_data_type map_box(logic signed [IN_BITS-1:0] bx_in,
                                            logic signed [IN_BITS-1:0] by_in,
                                            logic [COORD_BITS-1:0] bw_in,
                                            logic [COORD_BITS-1:0] bh_in);
      rsp_data_type r;
      longint bx, by, bw, bh, p, q, rx, ry, rw, rh, x0, y0, x1, y1;
      bit width_smaller;
      r = '0;
      bx = longint'(bx_in);
      by = longint'(by_in);
      bw = longint'(bw_in);
      bh = longint'(bh_in);
      if (frame_w == 0 || frame_h == 0 || prev_w == 0 || prev_h == 0) return r;
      width_smaller = (prev_w * frame_h) <= (prev_h * frame_w);
      if (letterbox ? width_smaller : !width_smaller) begin
         p = prev_w;
         q = frame_w;
      end else begin
         p = prev_h;
         q = frame_h;
      end
      rx = floor_div(prev_w * q - frame_w * p + 2 * bx * p + q, 2 * q);
      ry = floor_div(prev_h * q - frame_h * p + 2 * by * p + q, 2 * q);
      rw = floor_div(2 * bw * p + q, 2 * q);
      rh = floor_div(2 * bh * p + q, 2 * q);
      x0 = rx > 0 ? rx : 0;
      y0 = ry > 0 ? ry : 0;
      x1 = (rx + rw) < prev_w ? (rx + rw) : prev_w;
      y1 = (ry + rh) < prev_h ? (ry + rh) : prev_h;
      if (x1 <= x0 || y1 <= y0) return r;
      r.disp_x = x0[COORD_BITS-1:0];
      r.disp_y = y0[COORD_BITS-1:0];
      r.disp_w = COORD_BITS'(x1 - x0);
      r.disp_h = COORD_BITS'(y1 - y0);
      return r;
   endfunction

   // One APB write: setup cycle, then access cycle.
   task automatic write_reg(reg_index_type idx, logic [DATA_BITS-1:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ADDR_BITS'(idx) << 2;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_FRAME_W:   frame_w = longint'(value[COORD_BITS-1:0]);
         REG_FRAME_H:   frame_h = longint'(value[COORD_BITS-1:0]);
         REG_PREVIEW_W: prev_w = longint'(value[COORD_BITS-1:0]);
         REG_PREVIEW_H: prev_h = longint'(value[COORD_BITS-1:0]);
         default:       letterbox = value[0];
      endcase
   endtask

   task automatic set_geometry(int fw, int fh, int pw, int ph, bit mode);
      write_reg(REG_FRAME_W, DATA_BITS'(fw));
      write_reg(REG_FRAME_H, DATA_BITS'(fh));
      write_reg(REG_PREVIEW_W, DATA_BITS'(pw));
      write_reg(REG_PREVIEW_H, DATA_BITS'(ph));
      write_reg(REG_MODE, DATA_BITS'(mode));
   endtask

   // Offers one request, idling first at the chosen rate, and waits for acceptance.
   task automatic send_box(logic signed [IN_BITS-1:0] bx, logic signed [IN_BITS-1:0] by,
                           logic [COORD_BITS-1:0] bw, logic [COORD_BITS-1:0] bh,
                           bit has_exp, rsp_data_type exp);
      rsp_data_type pred;
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.box_x <= bx;
      req_if.box_y <= by;
      req_if.box_w <= bw;
      req_if.box_h <= bh;
      pred = map_box(bx, by, bw, bh);
      if (has_exp && pred != exp)
         $display("note: typed expectation differs from prediction at %0d %0d", bx, by);
      do @(posedge clock); while (!req_if.ready);
      expected_boxes.push_back(has_exp ? exp : pred);
   endtask

   task automatic end_burst();
      req_if.valid <= 1'b0;
   endtask

   task automatic drain();
      @(posedge clock);
      while (expected_boxes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_random(int count, bit well_formed);
      logic signed [IN_BITS-1:0] bx, by;
      logic [COORD_BITS-1:0] bw, bh;
      for (int i = 0; i < count; i++) begin
         if (well_formed && frame_w != 0 && frame_h != 0) begin
            bx = IN_BITS'($urandom_range(32'(frame_w + 40)) - 20);
            by = IN_BITS'($urandom_range(32'(frame_h + 40)) - 20);
            bw = COORD_BITS'($urandom_range(32'(frame_w)));
            bh = COORD_BITS'($urandom_range(32'(frame_h)));
         end else begin
            bx = IN_BITS'($urandom);
            by = IN_BITS'($urandom);
            bw = COORD_BITS'($urandom);
            bh = COORD_BITS'($urandom);
         end
         send_box(bx, by, bw, bh, 1'b0, '0);
      end
      end_burst();
   endtask

   // Result side: random stalls, long hold-off on request, compare with oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_boxes.size() == 0) begin
               errors++;
               if (errors <= 10) $display("mismatch: result with nothing expected");
            end else begin
               rsp_data_type e;
               e = expected_boxes.pop_front();
               if (rsp_if.disp_x !== e.disp_x || rsp_if.disp_y !== e.disp_y ||
                   rsp_if.disp_w !== e.disp_w || rsp_if.disp_h !== e.disp_h) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                              e.disp_x, e.disp_y, e.disp_w, e.disp_h, rsp_if.disp_x,
                              rsp_if.disp_y, rsp_if.disp_w, rsp_if.disp_h);
               end
            end
         end
         rsp_if.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog on cycles without any accepted request or result.
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Long receiver hold-off while the sender keeps offering.
   initial begin
      wait (!reset);
      wait (expected_boxes.size() > 20);
      recv_hold = 1'b1;
      repeat (200) @(posedge clock);
      recv_hold = 1'b0;
   end

   stim_row_type directed[$];

   task automatic add_row(int x, int y, int w, int h, bit has_exp,
                          int ex, int ey, int ew, int eh);
      stim_row_type r;
      r.x = IN_BITS'(x);
      r.y = IN_BITS'(y);
      r.w = COORD_BITS'(w);
      r.h = COORD_BITS'(h);
      r.has_exp = has_exp;
      r.exp = {COORD_BITS'(ex), COORD_BITS'(ey), COORD_BITS'(ew), COORD_BITS'(eh)};
      directed.push_back(r);
   endtask

   initial begin
      frame_w = 0;
      frame_h = 0;
      prev_w = 0;
      prev_h = 0;
      letterbox = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // After reset all sizes are zero, so every box maps to zeros.
      add_row(0, 0, 10, 10, 1, 0, 0, 0, 0);
      add_row(4095, -4096, 4095, 4095, 1, 0, 0, 0, 0);
      foreach (directed[i])
         send_box(directed[i].x, directed[i].y, directed[i].w, directed[i].h,
                  directed[i].has_exp, directed[i].exp);
      end_burst();
      drain();

      // Identity scale: boxes pass unchanged, clipped at the edges.
      directed.delete();
      set_geometry(100, 100, 100, 100, 1);
      add_row(10, 20, 30, 40, 1, 10, 20, 30, 40);
      add_row(-10, -10, 30, 30, 1, 0, 0, 20, 20);
      add_row(90, 90, 30, 30, 1, 90, 90, 10, 10);
      add_row(100, 0, 10, 10, 1, 0, 0, 0, 0);
      add_row(10, 10, 0, 10, 1, 0, 0, 0, 0);
      add_row(-4096, -4096, 4095, 4095, 1, 0, 0, 0, 0);
      add_row(4095, 4095, 4095, 4095, 1, 0, 0, 0, 0);
      add_row(0, 0, 4095, 4095, 1, 0, 0, 100, 100);
      foreach (directed[i])
         send_box(directed[i].x, directed[i].y, directed[i].w, directed[i].h,
                  directed[i].has_exp, directed[i].exp);
      end_burst();
      drain();

      // Unequal aspect in both modes and at the size extremes.
      directed.delete();
      set_geometry(640, 480, 320, 320, 1);
      add_row(0, 0, 640, 480, 0, 0, 0, 0, 0);
      add_row(-1, -1, 3, 3, 0, 0, 0, 0, 0);
      add_row(639, 479, 1, 1, 0, 0, 0, 0, 0);
      foreach (directed[i])
         send_box(directed[i].x, directed[i].y, directed[i].w, directed[i].h, 0, '0);
      end_burst();
      drain();
      write_reg(REG_MODE, DATA_BITS'(0));
      foreach (directed[i])
         send_box(directed[i].x, directed[i].y, directed[i].w, directed[i].h, 0, '0);
      end_burst();
      drain();
      set_geometry(4095, 1, 1, 4095, 0);
      send_random(6, 0);
      drain();
      set_geometry(1, 4095, 4095, 1, 1);
      send_random(6, 0);
      drain();

      // Random phases over several geometries and idle patterns.
      for (int phase = 0; phase < 15; phase++) begin
         case (phase / 5)
            0: begin send_idle_pct = 30; recv_idle_pct = 47; end
            1: begin send_idle_pct = 47; recv_idle_pct = 30; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         if (phase == 3)
            set_geometry(4095, 4095, 4095, 4095, phase[0]);
         else if (phase == 7)
            set_geometry(0, $urandom_range(1, 4095), 100, 100, 1);
         else
            set_geometry($urandom_range(1, 4095), $urandom_range(1, 4095),
                         $urandom_range(1, 4095), $urandom_range(1, 4095), 1'($urandom));
         send_random(85, 1);
         send_random(20, 0);
         drain();
      end

      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0 && expected_boxes.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule
